FILE: rtl/core/mstt_pkg.sv
`timescale 1ns / 1ps
package mstt_pkg;

  localparam int unsigned TIME_W     = 48;
  localparam int unsigned TMO_W      = 32;
  localparam int unsigned PERIOD_W   = 31;
  localparam int unsigned WAIT_W     = 21;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 32;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PROCESS = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] RK_FIRED  = 2'd0;
  localparam logic [KIND_W-1:0] RK_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] RK_WAIT   = 2'd2;
  localparam logic [KIND_W-1:0] RK_CANCEL = 2'd3;

  typedef struct packed {
    logic [IN_DATA_W-TIME_W-ID_W-1-TMO_W-1:0] pad;
    logic [TIME_W-1:0]                        now;
    logic [ID_W-1:0]                          timer_id;
    logic                                     one_shot;
    logic [TMO_W-1:0]                         timeout_ms;
  } in_data_t;

  typedef struct packed {
    logic [OUT_DATA_W-WAIT_W-ID_W-1:0] pad;
    logic [WAIT_W-1:0]                 wait_time;
    logic [ID_W-1:0]                   out_id;
  } out_data_t;

  typedef struct packed {
    logic                one_shot;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   fire_time;
  } slot_entry_t;

  // Request to the shared adder and comparator.
  typedef struct packed {
    logic              sub;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] cmp_a;
    logic [TIME_W-1:0] cmp_b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] res;
    logic              lt;
    logic              eq;
  } alu_rsp_t;

endpackage

FILE: rtl/core/mstt_ram.sv
`timescale 1ns / 1ps
module mstt_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mstt_alu.sv
`timescale 1ns / 1ps
module mstt_alu (
  input  mstt_pkg::alu_req_t req_i,
  output mstt_pkg::alu_rsp_t rsp_o
);
  import mstt_pkg::*;

  logic [TIME_W:0] sum;

  always_comb begin
    if (req_i.sub) begin
      sum = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
    // An add that carries out saturates at the largest time value.
    if (!req_i.sub && sum[TIME_W]) begin
      rsp_o.res = '1;
    end else begin
      rsp_o.res = sum[TIME_W-1:0];
    end
    rsp_o.lt = (req_i.cmp_a < req_i.cmp_b);
    rsp_o.eq = (req_i.cmp_a == req_i.cmp_b);
  end

endmodule

FILE: rtl/core/multi_slot_timer_table_top.sv
`timescale 1ns / 1ps
// Timer table with SLOTS one-shot or repeating slots.
// Input channel (s_axis): tuser carries the item kind (add, cancel, process);
// tdata carries timeout_ms, one_shot, timer_id and now. Ready is high only
// while the sequencer is idle, so one item is worked on at a time.
// Output channel (m_axis): tuser carries the result kind, tdata the id and
// the wait value, tlast marks the final result of an item.
// Add searches for the lowest free slot, writes it and updates the next
// deadline; a full table or a negative timeout answers with id zero.
// Cancel of an active id and process walk every slot to rebuild the next
// deadline, and process then forms the wait value; each slot passes the EVAL
// and MIN states on the single slot RAM read port and the shared adder/comparator.
// A cancel of an id that is free or out of range answers without a walk.
// Results leave through one output register, which is refilled in the cycle
// it is taken. When the receiver stalls, the sequencer holds at the next
// result until the register frees up; nothing is dropped.
// Reset clears the slot active bits, the next deadline and the output
// register. Slot contents need no clearing; no clearing pass is run.
module multi_slot_timer_table_top #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned WAIT_CAP = 1000000
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // timeout_ms [31:0], one_shot [32], timer_id [40:33], now [88:41]
  input  logic [mstt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind [1:0]
  input  logic [mstt_pkg::KIND_W-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // out_id [7:0], wait_time [28:8]
  output logic [mstt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // result_kind [1:0]
  output logic [mstt_pkg::KIND_W-1:0]     m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import mstt_pkg::*;

  localparam int unsigned      IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [ID_W-1:0]  SLOTS_ID = ID_W'(SLOTS);
  localparam logic [TIME_W-1:0] CAP_T   = TIME_W'(WAIT_CAP);
  localparam logic [WAIT_W-1:0] CAP_W   = WAIT_W'(WAIT_CAP);
  localparam int unsigned      ENT_W    = $bits(slot_entry_t);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FIND = 4'd1;
  localparam logic [3:0] ST_ADD  = 4'd2;
  localparam logic [3:0] ST_AMIN = 4'd3;
  localparam logic [3:0] ST_EVAL = 4'd4;
  localparam logic [3:0] ST_MIN  = 4'd5;
  localparam logic [3:0] ST_WSUB = 4'd6;
  localparam logic [3:0] ST_WCAP = 4'd7;
  localparam logic [3:0] ST_EMIT = 4'd8;

  // Control state.
  logic [3:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SLOTS-1:0]  active_q, active_d;
  logic [TIME_W-1:0] nd_q, nd_d;
  logic              proc_q, proc_d;
  logic              out_vld_q, out_vld_d;

  // Payload.
  logic [TIME_W-1:0]   now_q, now_d;
  logic [PERIOD_W-1:0] tmo_q, tmo_d;
  logic                one_shot_q, one_shot_d;
  logic [KIND_W-1:0]   rsp_kind_q, rsp_kind_d;
  logic [ID_W-1:0]     rsp_id_q, rsp_id_d;
  logic [TIME_W-1:0]   cand_q, cand_d;
  logic                cand_vld_q, cand_vld_d;
  logic [TIME_W-1:0]   diff_q, diff_d;
  logic                late_q, late_d;
  logic [KIND_W-1:0]   out_kind_q, out_kind_d;
  logic [ID_W-1:0]     out_id_q, out_id_d;
  logic [WAIT_W-1:0]   out_wait_q, out_wait_d;
  logic                out_last_q, out_last_d;

  in_data_t      in_data;
  out_data_t     out_data;
  slot_entry_t   ent;
  slot_entry_t   wr_ent;
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;
  logic          ram_we;
  logic [ENT_W-1:0] ram_rdata;
  logic          out_free;
  logic [ID_W-1:0]  tid_m1;
  logic [IDX_W-1:0] tid_idx;
  logic          cancel_hit;
  logic [ID_W-1:0]  slot_id;
  logic          expired;

  assign in_data  = in_data_t'(s_axis_tdata_i);
  assign ent      = slot_entry_t'(ram_rdata);
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign tid_m1   = in_data.timer_id - ID_W'(1);
  assign tid_idx  = tid_m1[IDX_W-1:0];
  assign cancel_hit = (in_data.timer_id != '0) && (in_data.timer_id <= SLOTS_ID) &&
                      active_q[tid_idx];
  assign slot_id  = ID_W'(idx_q) + ID_W'(1);

  mstt_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Read address follows the next index, so the entry for idx_q is ready in the following cycle.
  mstt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (wr_ent),
    .raddr_i (idx_d),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    active_d   = active_q;
    nd_d       = nd_q;
    proc_d     = proc_q;
    now_d      = now_q;
    tmo_d      = tmo_q;
    one_shot_d = one_shot_q;
    rsp_kind_d = rsp_kind_q;
    rsp_id_d   = rsp_id_q;
    cand_d     = cand_q;
    cand_vld_d = cand_vld_q;
    diff_d     = diff_q;
    late_d     = late_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_kind_d = out_kind_q;
    out_id_d   = out_id_q;
    out_wait_d = out_wait_q;
    out_last_d = out_last_q;
    ram_we     = 1'b0;
    wr_ent     = ent;
    alu_req    = '0;
    expired    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          now_d      = in_data.now;
          tmo_d      = in_data.timeout_ms[PERIOD_W-1:0];
          one_shot_d = in_data.one_shot;
          idx_d      = '0;
          case (s_axis_tuser_i)
            KIND_ADD: begin
              rsp_kind_d = RK_ADD;
              rsp_id_d   = '0;
              state_d    = in_data.timeout_ms[TMO_W-1] ? ST_EMIT : ST_FIND;
            end
            KIND_CANCEL: begin
              rsp_kind_d = RK_CANCEL;
              rsp_id_d   = in_data.timer_id;
              if (cancel_hit) begin
                active_d[tid_idx] = 1'b0;
                nd_d    = '0;
                proc_d  = 1'b0;
                state_d = ST_EVAL;
              end else begin
                state_d = ST_EMIT;
              end
            end
            KIND_PROCESS: begin
              nd_d    = '0;
              proc_d  = 1'b1;
              state_d = ST_EVAL;
            end
            default: begin
              // Unknown kinds are dropped without a result.
            end
          endcase
        end
      end
      ST_FIND: begin
        if (!active_q[idx_q]) begin
          state_d = ST_ADD;
        end else if (idx_q == LAST_IDX) begin
          state_d = ST_EMIT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_ADD: begin
        alu_req.a = now_q;
        alu_req.b = TIME_W'(tmo_q);
        ram_we    = 1'b1;
        wr_ent.one_shot  = one_shot_q;
        // A zero-period interval would refire forever; it runs at period one.
        wr_ent.period    = ((tmo_q == '0) && !one_shot_q) ? PERIOD_W'(1) : tmo_q;
        wr_ent.fire_time = alu_rsp.res;
        active_d[idx_q]  = 1'b1;
        cand_d  = alu_rsp.res;
        state_d = ST_AMIN;
      end
      ST_AMIN: begin
        alu_req.cmp_a = cand_q;
        alu_req.cmp_b = nd_q;
        if ((nd_q == '0) || alu_rsp.lt) begin
          nd_d = cand_q;
        end
        rsp_id_d = slot_id;
        state_d  = ST_EMIT;
      end
      ST_EVAL: begin
        alu_req.a     = now_q;
        alu_req.b     = TIME_W'(ent.period);
        alu_req.cmp_a = ent.fire_time;
        alu_req.cmp_b = now_q;
        expired = proc_q && active_q[idx_q] && (alu_rsp.lt || alu_rsp.eq);
        if (!expired || out_free) begin
          cand_d     = ent.fire_time;
          cand_vld_d = active_q[idx_q];
          if (expired) begin
            out_vld_d  = 1'b1;
            out_kind_d = RK_FIRED;
            out_id_d   = slot_id;
            out_wait_d = '0;
            out_last_d = 1'b0;
            if (ent.one_shot) begin
              active_d[idx_q] = 1'b0;
              cand_vld_d      = 1'b0;
            end else begin
              ram_we           = 1'b1;
              wr_ent.fire_time = alu_rsp.res;
              cand_d           = alu_rsp.res;
            end
          end
          state_d = ST_MIN;
        end
      end
      ST_MIN: begin
        alu_req.cmp_a = cand_q;
        alu_req.cmp_b = nd_q;
        // Slot order matters: a zero deadline counts as none and is replaced.
        if (cand_vld_q && ((nd_q == '0) || alu_rsp.lt)) begin
          nd_d = cand_q;
        end
        if (idx_q == LAST_IDX) begin
          state_d = proc_q ? ST_WSUB : ST_EMIT;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_EVAL;
        end
      end
      ST_WSUB: begin
        alu_req.sub   = 1'b1;
        alu_req.a     = nd_q;
        alu_req.b     = now_q;
        alu_req.cmp_a = nd_q;
        alu_req.cmp_b = now_q;
        diff_d  = alu_rsp.res;
        late_d  = alu_rsp.lt || alu_rsp.eq;
        state_d = ST_WCAP;
      end
      ST_WCAP: begin
        alu_req.cmp_a = CAP_T;
        alu_req.cmp_b = diff_q;
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = RK_WAIT;
          out_id_d   = '0;
          out_last_d = 1'b1;
          if (late_q) begin
            out_wait_d = '1;
          end else if (alu_rsp.lt) begin
            out_wait_d = CAP_W;
          end else begin
            out_wait_d = diff_q[WAIT_W-1:0];
          end
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = rsp_kind_q;
          out_id_d   = rsp_id_q;
          out_wait_d = '0;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      active_q  <= '0;
      nd_q      <= '0;
      proc_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      active_q  <= active_d;
      nd_q      <= nd_d;
      proc_q    <= proc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    tmo_q      <= tmo_d;
    one_shot_q <= one_shot_d;
    rsp_kind_q <= rsp_kind_d;
    rsp_id_q   <= rsp_id_d;
    cand_q     <= cand_d;
    cand_vld_q <= cand_vld_d;
    diff_q     <= diff_d;
    late_q     <= late_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_wait_q <= out_wait_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    out_data.pad       = '0;
    out_data.wait_time = out_wait_q;
    out_data.out_id    = out_id_q;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

FILE: test/multi_slot_timer_table_checker.sv
`timescale 1ns / 1ps
module multi_slot_timer_table_checker #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned WAIT_CAP = 1000000
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [mstt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [mstt_pkg::KIND_W-1:0]     s_axis_tuser_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  input  logic [mstt_pkg::OUT_DATA_W-1:0] m_axis_tdata_i,
  input  logic [mstt_pkg::KIND_W-1:0]     m_axis_tuser_i,
  input  logic                            m_axis_tlast_i,
  output int unsigned                     errors_o,
  output int unsigned                     outstanding_o,
  output int unsigned                     requests_o,
  output int unsigned                     results_o,
  output int unsigned                     fired_o
);
  import mstt_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [WAIT_W-1:0] wait_ticks;
    logic              last;
  } timer_result_t;

  localparam logic [WAIT_W-1:0] WAIT_NONE = '1;

  // Shadow copy of the timer table.
  logic                slot_busy   [SLOTS];
  logic                slot_once   [SLOTS];
  logic [PERIOD_W-1:0] slot_period [SLOTS];
  logic [TIME_W-1:0]   slot_due    [SLOTS];
  logic [TIME_W-1:0]   earliest_due;

  timer_result_t awaited_results[$];
  int unsigned   n_errors;
  int unsigned   n_requests;
  int unsigned   n_results;
  int unsigned   n_fired;

  function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W-1:0] t,
                                                input logic [TIME_W-1:0] d);
    logic [TIME_W:0] s;
    s = t + d;
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic void rebuild_earliest_due();
    earliest_due = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_busy[i] && (earliest_due == '0 || slot_due[i] < earliest_due)) begin
        earliest_due = slot_due[i];
      end
    end
  endfunction

  function automatic void queue_result(input logic [KIND_W-1:0] kind,
                                       input logic [ID_W-1:0] id,
                                       input logic [WAIT_W-1:0] ticks,
                                       input logic last);
    timer_result_t r;
    r.kind       = kind;
    r.id         = id;
    r.wait_ticks = ticks;
    r.last       = last;
    awaited_results.push_back(r);
  endfunction

  task automatic step_timer_table(input logic [KIND_W-1:0] kind, input in_data_t d);
    int unsigned       slot;
    logic [ID_W-1:0]   new_id;
    logic [TIME_W-1:0] gap;
    logic [WAIT_W-1:0] ticks;
    case (kind)
      KIND_ADD: begin
        n_requests++;
        new_id = '0;
        if (!d.timeout_ms[TMO_W-1]) begin
          slot = SLOTS;
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_busy[i] && slot == SLOTS) slot = i;
          end
          if (slot < SLOTS) begin
            slot_busy[slot]   = 1'b1;
            slot_once[slot]   = d.one_shot;
            slot_period[slot] = d.timeout_ms[PERIOD_W-1:0];
            // A repeating timer with no period would fire forever in one pass.
            if (d.timeout_ms == '0 && !d.one_shot) slot_period[slot] = PERIOD_W'(1);
            slot_due[slot] = sat_sum(d.now, TIME_W'(d.timeout_ms[PERIOD_W-1:0]));
            if (earliest_due == '0 || slot_due[slot] < earliest_due) begin
              earliest_due = slot_due[slot];
            end
            new_id = ID_W'(slot + 1);
          end
        end
        queue_result(RK_ADD, new_id, '0, 1'b1);
      end
      KIND_CANCEL: begin
        n_requests++;
        if (d.timer_id != '0 && d.timer_id <= SLOTS) begin
          if (slot_busy[d.timer_id - 1]) begin
            slot_busy[d.timer_id - 1] = 1'b0;
            rebuild_earliest_due();
          end
        end
        queue_result(RK_CANCEL, d.timer_id, '0, 1'b1);
      end
      KIND_PROCESS: begin
        n_requests++;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i] && slot_due[i] <= d.now) begin
            queue_result(RK_FIRED, ID_W'(i + 1), '0, 1'b0);
            n_fired++;
            if (slot_once[i]) begin
              slot_busy[i] = 1'b0;
            end else begin
              slot_due[i] = sat_sum(d.now, TIME_W'(slot_period[i]));
            end
          end
        end
        rebuild_earliest_due();
        // A zero deadline also means nothing is pending.
        if (earliest_due <= d.now) begin
          ticks = WAIT_NONE;
        end else begin
          gap   = earliest_due - d.now;
          ticks = (gap > WAIT_CAP) ? WAIT_W'(WAIT_CAP) : gap[WAIT_W-1:0];
        end
        queue_result(RK_WAIT, '0, ticks, 1'b1);
      end
      default: begin
        // Unknown kinds are dropped by the block.
      end
    endcase
  endtask

  task automatic check_result(input logic [KIND_W-1:0] kind, input out_data_t od,
                              input logic last);
    timer_result_t got;
    timer_result_t want;
    got.kind       = kind;
    got.id         = od.out_id;
    got.wait_ticks = od.wait_time;
    got.last       = last;
    n_results++;
    if (awaited_results.size() == 0) begin
      if (n_errors < 10) begin
        $display("%0t: unexpected result kind %0d id %0d wait %0d last %0b", $time,
                 got.kind, got.id, $signed(got.wait_ticks), got.last);
      end
      n_errors++;
    end else begin
      want = awaited_results.pop_front();
      if (got.kind != want.kind || got.id != want.id ||
          got.wait_ticks != want.wait_ticks || got.last != want.last) begin
        if (n_errors < 10) begin
          $display("%0t: result mismatch, expected kind %0d id %0d wait %0d last %0b",
                   $time, want.kind, want.id, $signed(want.wait_ticks), want.last);
          $display("%0t:                   got kind %0d id %0d wait %0d last %0b",
                   $time, got.kind, got.id, $signed(got.wait_ticks), got.last);
        end
        n_errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_busy[i]   = 1'b0;
        slot_once[i]   = 1'b0;
        slot_period[i] = '0;
        slot_due[i]    = '0;
      end
      earliest_due = '0;
      awaited_results.delete();
      n_errors   = 0;
      n_requests = 0;
      n_results  = 0;
      n_fired    = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        step_timer_table(s_axis_tuser_i, in_data_t'(s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_result(m_axis_tuser_i, out_data_t'(m_axis_tdata_i), m_axis_tlast_i);
      end
    end
    errors_o      <= n_errors;
    outstanding_o <= awaited_results.size();
    requests_o    <= n_requests;
    results_o     <= n_results;
    fired_o       <= n_fired;
  end

endmodule

FILE: test/multi_slot_timer_table_top_tb.sv
`timescale 1ns / 1ps
module multi_slot_timer_table_top_tb;
  import mstt_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX    = '1;
  localparam int unsigned       QUIET_LIMIT = 4000;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [KIND_W-1:0]     s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;

  int unsigned       errors;
  int unsigned       outstanding;
  int unsigned       requests;
  int unsigned       results;
  int unsigned       fired;
  int unsigned       idle_pct  = 0;
  int unsigned       stall_pct = 0;
  int unsigned       quiet_cycles = 0;
  logic [TIME_W-1:0] clock_now = '0;

  always #10 clk = ~clk;

  multi_slot_timer_table_top DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  multi_slot_timer_table_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .errors_o        (errors),
    .outstanding_o   (outstanding),
    .requests_o      (requests),
    .results_o       (results),
    .fired_o         (fired)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Ends the run if neither channel completes a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog expired at %0t with %0d results outstanding", $time, outstanding);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic offer_request(input logic [KIND_W-1:0] kind, input logic [TMO_W-1:0] tmo,
                               input logic one_shot, input logic [ID_W-1:0] tid,
                               input logic [TIME_W-1:0] at);
    in_data_t d;
    d            = '0;
    d.timeout_ms = tmo;
    d.one_shot   = one_shot;
    d.timer_id   = tid;
    d.now        = at;
    s_tdata  <= d;
    s_tuser  <= kind;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic run_directed();
    // An empty table, then a one-shot whose fire time of zero reads as no deadline.
    offer_request(KIND_PROCESS, '0, 1'b0, '0, '0);
    offer_request(KIND_ADD, 32'd0, 1'b1, '0, '0);
    offer_request(KIND_PROCESS, '0, 1'b0, '0, '0);
    offer_request(KIND_ADD, 32'hFFFF_FFFF, 1'b0, '1, TIME_MAX);
    offer_request(KIND_ADD, 32'h8000_0000, 1'b1, '0, 48'd100);
    offer_request(KIND_ADD, 32'd0, 1'b0, '0, 48'd100);
    offer_request(KIND_ADD, 32'd0, 1'b1, '0, 48'd100);
    offer_request(KIND_ADD, 32'h7FFF_FFFF, 1'b0, '0, 48'd100);
    offer_request(KIND_PROCESS, '0, 1'b0, '0, 48'd100);
    offer_request(KIND_CANCEL, '0, 1'b0, 8'd1, '0);
    offer_request(KIND_CANCEL, '0, 1'b0, 8'd1, '0);
    offer_request(KIND_CANCEL, '0, 1'b0, 8'd0, '0);
    offer_request(KIND_CANCEL, '1, 1'b1, 8'd255, TIME_MAX);
    offer_request(KIND_PROCESS, '0, 1'b0, '0, 48'd200);
    offer_request(KIND_UNUSED, $urandom, 1'b1, 8'd2, 48'd200);
    // Fill every free slot; one interval lands beyond the end of time.
    for (int i = 0; i < 15; i++) begin
      if (i == 7) begin
        offer_request(KIND_ADD, 32'd1000, 1'b0, '0, TIME_MAX - 5);
      end else begin
        offer_request(KIND_ADD, $urandom_range(500, 1), 1'b1, '0, 48'd300);
      end
    end
    offer_request(KIND_ADD, 32'd10, 1'b1, '0, 48'd300);
    offer_request(KIND_PROCESS, '0, 1'b0, '0, TIME_MAX);
    offer_request(KIND_CANCEL, '0, 1'b0, 8'd3, '0);
    offer_request(KIND_CANCEL, '0, 1'b0, 8'd9, '0);
    clock_now = 48'd1000;
  endtask

  task automatic run_random_phase(input int unsigned count);
    int unsigned     done;
    int unsigned     sel;
    logic [TMO_W-1:0] tmo;
    logic [ID_W-1:0]  tid;
    logic             one_shot;
    logic [TIME_W-1:0] noise_time;
    done = 0;
    while (done < count) begin
      sel        = $urandom_range(99);
      tmo        = $urandom;
      tid        = ID_W'($urandom);
      one_shot   = 1'($urandom_range(1));
      noise_time = TIME_W'({$urandom, $urandom});
      if (sel < 45) begin
        case ($urandom_range(19))
          0:       tmo = '0;
          1, 2:    ;
          default: tmo = $urandom_range(200);
        endcase
        offer_request(KIND_ADD, tmo, one_shot, tid, clock_now);
        done++;
      end else if (sel < 65) begin
        if ($urandom_range(9) < 7) tid = ID_W'($urandom_range(16, 1));
        offer_request(KIND_CANCEL, tmo, one_shot, tid, noise_time);
        done++;
      end else if (sel < 95) begin
        case ($urandom_range(29))
          0:       clock_now = noise_time;
          1:       clock_now = TIME_MAX - $urandom_range(100);
          default: clock_now = clock_now + $urandom_range(150);
        endcase
        offer_request(KIND_PROCESS, tmo, one_shot, tid, clock_now);
        done++;
      end else begin
        offer_request(KIND_UNUSED, tmo, one_shot, tid, noise_time);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random_phase(80);
    s_tvalid <= 1'b0;
    wait_drained();
    idle_pct = 77;
    run_random_phase(80);
    idle_pct  = 0;
    stall_pct = 77;
    run_random_phase(80);
    idle_pct  = 38;
    stall_pct = 38;
    run_random_phase(80);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk);
    $display("Covered %0d timer requests across four pacing phases, table full and saturation.",
             requests);
    $display("Compared %0d results, %0d of them timer expirations.", results, fired);
    if (errors == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
